[rtl/core/mtmr_pkg.sv]
// ----------------------------------------------------------------------------
// mtmr_pkg
// Shared types and codes for the four-channel match timer.
// ----------------------------------------------------------------------------
package mtmr_pkg;

  localparam int CHANNELS   = 4;
  localparam int DATA_W     = 32;
  localparam int PEND_W     = 4;
  localparam int MATCH_SELS = 4;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [2:0] SEL_COUNT  = 3'd4;
  localparam logic [2:0] SEL_STATUS = 3'd5;
  localparam logic [2:0] SEL_ENABLE = 3'd6;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        reg_select;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [PEND_W-1:0] pending_lines;
    logic              irq;
  } result_t;

  typedef struct packed {
    logic advance;
    logic fire;
  } pipe_ctl_t;

endpackage

[rtl/core/mtmr_in_stage.sv]
// ----------------------------------------------------------------------------
// mtmr_in_stage
// Input register: captures one word whenever the stage is empty or draining.
// ----------------------------------------------------------------------------
module mtmr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtmr_pkg::item_t     in_item,
  input  logic                advance,
  output logic                item_valid,
  output mtmr_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  mtmr_pkg::item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/core/mtmr_core.sv]
// ----------------------------------------------------------------------------
// mtmr_core
// Timer state: counter, match registers, status and enable. Applies one word
// per fire and produces its result from the updated state.
// ----------------------------------------------------------------------------
module mtmr_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  mtmr_pkg::item_t                      item,
  output mtmr_pkg::result_t                    res,
  output logic [mtmr_pkg::DATA_W-1:0]          count
);

  localparam int CH = mtmr_pkg::CHANNELS;
  localparam int DW = mtmr_pkg::DATA_W;

  logic [DW-1:0] count_r, count_nxt, count_inc;
  logic [DW-1:0] match_r   [CH];
  logic [DW-1:0] match_nxt [CH];
  logic [CH-1:0] status_r, status_nxt;
  logic [CH-1:0] enable_r, enable_nxt;
  logic [CH-1:0] hits;
  logic [CH-1:0] pend;
  logic [DW-1:0] rd;
  logic          is_tick, is_read, is_write;

  assign is_tick  = item.action == mtmr_pkg::ACT_TICK;
  assign is_read  = item.action == mtmr_pkg::ACT_READ;
  assign is_write = item.action == mtmr_pkg::ACT_WRITE;
  assign count_inc = count_r + {{(DW-1){1'b0}}, 1'b1};

  always_comb begin
    for (int n = 0; n < CH; n++) begin
      hits[n] = match_r[n] == count_inc;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    enable_nxt = enable_r;
    for (int n = 0; n < CH; n++) begin
      match_nxt[n] = match_r[n];
    end
    if (is_tick) begin
      count_nxt  = count_inc;
      status_nxt = status_r | hits;
    end else if (is_write) begin
      for (int n = 0; n < CH; n++) begin
        if (n < mtmr_pkg::MATCH_SELS && item.reg_select == 3'(n)) begin
          match_nxt[n] = item.write_data;
        end
      end
      case (item.reg_select)
        mtmr_pkg::SEL_COUNT:  count_nxt  = item.write_data;
        mtmr_pkg::SEL_STATUS: status_nxt = status_r & ~item.write_data[CH-1:0];
        mtmr_pkg::SEL_ENABLE: enable_nxt = item.write_data[CH-1:0];
        default: ;
      endcase
    end
  end

  // read mux on current state; reads change nothing
  always_comb begin
    rd = '0;
    if (is_read) begin
      for (int n = 0; n < CH; n++) begin
        if (n < mtmr_pkg::MATCH_SELS && item.reg_select == 3'(n)) begin
          rd = match_r[n];
        end
      end
      case (item.reg_select)
        mtmr_pkg::SEL_COUNT:  rd = count_r;
        mtmr_pkg::SEL_STATUS: rd = DW'(status_r);
        mtmr_pkg::SEL_ENABLE: rd = DW'(enable_r);
        default: ;
      endcase
    end
  end

  assign pend = status_nxt & enable_nxt;

  always_comb begin
    res.read_data     = rd;
    res.pending_lines = '0;
    for (int n = 0; n < mtmr_pkg::PEND_W; n++) begin
      if (n < CH) begin
        res.pending_lines[n] = pend[n % CH];
      end
    end
    res.irq = |pend;
  end

  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= '0;
      enable_r <= '0;
      for (int n = 0; n < CH; n++) begin
        match_r[n] <= '0;
      end
    end else if (fire) begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
      enable_r <= enable_nxt;
      for (int n = 0; n < CH; n++) begin
        match_r[n] <= match_nxt[n];
      end
    end
  end

endmodule

[rtl/core/mtmr_out_stage.sv]
// ----------------------------------------------------------------------------
// mtmr_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module mtmr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  mtmr_pkg::pipe_ctl_t ctl,
  input  mtmr_pkg::result_t   res,
  output logic                out_valid,
  output mtmr_pkg::result_t   out_res
);

  logic              valid_r, valid_nxt;
  mtmr_pkg::result_t res_r;

  assign valid_nxt = ctl.advance ? ctl.fire : valid_r;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/four_channel_match_timer_top.sv]
// ----------------------------------------------------------------------------
// four_channel_match_timer_top
// 32-bit counter, advanced by tick words, with four match-compare channels.
// ----------------------------------------------------------------------------
// Each input word is a tick, a register read or a register write, and yields
// exactly one result word carrying read data, the pending lines and irq after
// that word's update. Words pass an input register, combinational update logic
// and a result register; out_valid rises when the result register loads the word,
// and a new word is taken every cycle as long as out_ready is high. The
// four 32-bit equality compares against the incremented count set the
// critical path. Status bits are write-one-to-clear; irq is the OR of the
// enabled status bits.
module four_channel_match_timer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_reg_select,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [3:0]  out_pending_lines,
  output logic        out_irq
);

  mtmr_pkg::item_t     in_item;
  mtmr_pkg::item_t     item;
  logic                item_valid;
  mtmr_pkg::pipe_ctl_t ctl;
  mtmr_pkg::result_t   res;
  mtmr_pkg::result_t   out_res;
  logic [31:0]         count;

  assign in_item.action     = in_action;
  assign in_item.reg_select = in_reg_select;
  assign in_item.write_data = in_write_data;

  assign ctl.advance = !out_valid || out_ready;
  assign ctl.fire    = ctl.advance && item_valid;

  mtmr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (ctl.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mtmr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (ctl.fire),
    .item  (item),
    .res   (res),
    .count (count)
  );

  mtmr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_read_data     = out_res.read_data;
  assign out_pending_lines = out_res.pending_lines;
  assign out_irq           = out_res.irq;

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && item.action == mtmr_pkg::ACT_TICK |=> count == $past(count) + 32'd1)
    else $error("counter did not advance on tick");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.fire |=> count == $past(count))
    else $error("counter changed without a word");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !ctl.advance |=> item_valid && $stable(item))
    else $error("pending word lost during stall");

  a_irq_matches_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mtmr_pkg::CHANNELS <= 4 |-> out_irq == (|out_pending_lines))
    else $error("irq disagrees with pending lines");

endmodule
